### sv/bitmap_slot_allocator_mark_sweep_top_macros.svh
// Assertion macros used by the slot allocator back end.
`ifndef BITMAP_SLOT_ALLOCATOR_MARK_SWEEP_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MARK_SWEEP_TOP_MACROS_SVH
`ifndef SYNTH
`define BSAM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsam: same-cycle check failed");
`define BSAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsam: next-cycle check failed");
`else
`define BSAM_ASSERT_IMP(label, clk, rst, ante, cons)
`define BSAM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/bsam_pkg.sv
// Types and constants of the bitmap slot allocator.
package bsam_pkg;

   localparam int WORD_BITS = 64;
   localparam int SLOT_W    = 10;
   localparam int BIT_W     = 6;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_MARK  = 2'd2,
      OP_SWEEP = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic              pool_full;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic              in_range;
   } cmd_type;

   // front to back: head of the command queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // back to front
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_FM_RD,
      ST_FM_WR,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // position of the lowest clear bit; only meaningful for a word that is not full
   function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!w[b]) pos = BIT_W'(b);
      end
      return pos;
   endfunction

endpackage

### sv/bitmap_slot_allocator_mark_sweep_top.sv
// Slot allocator with mark and sweep: top level.
//
// Channels: req_ carries one operation word (op, slot_index), rsp_ returns one word
// (granted_slot, pool_full) per request, in order. csr_ writes reserved_slots, always
// ready; users write it only while the block has no request in flight; not enforced.
// Requests are queued two deep by the front end; a sequencer in the back end works on
// one at a time against two bitmap RAMs (allocation and mark), one 64-bit word each.
// Work per request, with WORDS = SLOTS/64:
//   free, mark:  read-modify-write of one word; none for a slot past the pool
//   alloc:       reads words up to the first one with a clear bit and sets that bit;
//                all WORDS words are read when the pool is full
//   sweep:       all WORDS words, one word of both maps per cycle
// The sequencer takes the next queued request only once the result of the last one
// has been loaded into the result word.
// Reset: both maps are zeroed by a pass over all WORDS words, one word per cycle;
// req_ready stays low during it and reserved_slots returns to 0.
// When rsp_ready is low the result word holds; the queue keeps taking requests until
// it fills, then req_ready drops.
module bitmap_slot_allocator_mark_sweep_top
   import bsam_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SLOT_W-1:0] csr_data
);

   logic [SLOT_W-1:0] reserved_ff, reserved_in;
   queue_head_type    q_head;
   back_ctl_type      back_ctl;

   assign csr_ready   = 1'b1;
   assign reserved_in = (csr_valid && csr_ready) ? csr_data : reserved_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else begin
         reserved_ff <= reserved_in;
      end
   end

   bsam_front #(.SLOTS(SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_head    (q_head),
      .back_ctl  (back_ctl)
   );

   bsam_back #(.SLOTS(SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .reserved  (reserved_ff),
      .q_head    (q_head),
      .back_ctl  (back_ctl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/bsam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsam_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/bsam_front.sv
// Front end: accepts request words, range-checks them and queues commands.
module bsam_front
   import bsam_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output queue_head_type q_head,
   input  back_ctl_type   back_ctl
);

   localparam int WORDS = SLOTS / WORD_BITS;
   localparam int POOL  = WORDS * WORD_BITS;

   cmd_type     fifo_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cmd;
   logic        push;
   logic        pop;

   always_comb begin
      cmd.op       = req_data.op;
      cmd.slot     = req_data.slot_index;
      cmd.in_range = (17'(req_data.slot_index) < 17'(POOL));
   end

   assign req_ready = (count_ff != 2'd2) && !back_ctl.clearing;
   assign push      = req_valid && req_ready;
   assign pop       = back_ctl.pop;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= cmd;
      end
   end

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.cmd   = fifo_ff[rptr_ff];

endmodule

### sv/bsam_back.sv
// Back end: sequencer that walks the bitmap RAMs and produces results.
`include "bitmap_slot_allocator_mark_sweep_top_macros.svh"
module bsam_back
   import bsam_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] reserved,
   input  queue_head_type    q_head,
   output back_ctl_type      back_ctl,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   localparam int WORDS = SLOTS / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW    = AW + 1;
   localparam int BW    = (AW + BIT_W + 1 > SLOT_W + 1) ? AW + BIT_W + 1 : SLOT_W + 1;

   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [AW-1:0]        chk_addr_ff, chk_addr_in;
   cmd_type              cur_ff, cur_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 a_we, a_re, m_we, m_re;
   logic [AW-1:0]        a_waddr, a_raddr, m_waddr, m_raddr;
   logic [WORD_BITS-1:0] a_wdata, m_wdata, a_rdata, m_rdata;

   logic [AW-1:0]        cur_word;
   logic [WORD_BITS-1:0] cur_bit;
   logic [BIT_W-1:0]     free_pos;
   logic [WORD_BITS-1:0] keep_mask;
   logic [BW-1:0]        res_ext, base_ext, diff;
   logic                 out_free;

   bsam_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_alloc_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (a_wdata),
      .re    (a_re),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   bsam_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_mark_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .re    (m_re),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   assign cur_word = AW'(cur_ff.slot[SLOT_W-1:BIT_W]);
   assign cur_bit  = WORD_BITS'(1) << cur_ff.slot[BIT_W-1:0];
   assign free_pos = lowest_clear(a_rdata);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sweep keeps bits of slots below the reserved count
   always_comb begin
      res_ext  = BW'(reserved);
      base_ext = BW'({chk_addr_ff, {BIT_W{1'b0}}});
      diff     = res_ext - base_ext;
      if (res_ext <= base_ext) begin
         keep_mask = '0;
      end else if (diff >= BW'(WORD_BITS)) begin
         keep_mask = '1;
      end else begin
         keep_mask = (WORD_BITS'(1) << diff[BIT_W-1:0]) - WORD_BITS'(1);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      chk_vld_in  = chk_vld_ff;
      chk_addr_in = chk_addr_ff;
      cur_in      = cur_ff;
      res_in      = res_ff;
      back_ctl.pop      = 1'b0;
      back_ctl.clearing = (state_ff == ST_CLEAR);
      a_we    = 1'b0;
      a_re    = 1'b0;
      m_we    = 1'b0;
      m_re    = 1'b0;
      a_waddr = chk_addr_ff;
      m_waddr = chk_addr_ff;
      a_raddr = cnt_ff[AW-1:0];
      m_raddr = cnt_ff[AW-1:0];
      a_wdata = '0;
      m_wdata = '0;

      case (state_ff)
         ST_CLEAR: begin
            a_we    = 1'b1;
            m_we    = 1'b1;
            a_waddr = cnt_ff[AW-1:0];
            m_waddr = cnt_ff[AW-1:0];
            if (cnt_ff == CW'(WORDS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (q_head.valid) begin
               back_ctl.pop = 1'b1;
               cur_in       = q_head.cmd;
               res_in       = '0;
               cnt_in       = '0;
               chk_vld_in   = 1'b0;
               case (q_head.cmd.op)
                  OP_ALLOC: state_in = ST_ALLOC;
                  OP_SWEEP: state_in = ST_SWEEP;
                  default: begin
                     if (q_head.cmd.in_range) state_in = ST_FM_RD;
                     else state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            // read one word a cycle, test the previous one
            if (cnt_ff != CW'(WORDS)) begin
               a_re        = 1'b1;
               cnt_in      = cnt_ff + CW'(1);
               chk_vld_in  = 1'b1;
               chk_addr_in = cnt_ff[AW-1:0];
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff && (a_rdata != '1)) begin
               a_we    = 1'b1;
               a_wdata = a_rdata | (WORD_BITS'(1) << free_pos);
               res_in.granted_slot = SLOT_W'({chk_addr_ff, free_pos});
               res_in.pool_full    = 1'b0;
               state_in = ST_DONE;
            end else if (!chk_vld_ff && (cnt_ff == CW'(WORDS))) begin
               res_in.granted_slot = '0;
               res_in.pool_full    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_FM_RD: begin
            a_re     = 1'b1;
            m_re     = 1'b1;
            a_raddr  = cur_word;
            m_raddr  = cur_word;
            state_in = ST_FM_WR;
         end
         ST_FM_WR: begin
            a_waddr = cur_word;
            m_waddr = cur_word;
            if (cur_ff.op == OP_FREE) begin
               a_we    = 1'b1;
               a_wdata = a_rdata & ~cur_bit;
            end else begin
               m_we    = 1'b1;
               m_wdata = m_rdata | cur_bit;
            end
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            if (cnt_ff != CW'(WORDS)) begin
               a_re        = 1'b1;
               m_re        = 1'b1;
               cnt_in      = cnt_ff + CW'(1);
               chk_vld_in  = 1'b1;
               chk_addr_in = cnt_ff[AW-1:0];
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               a_we    = 1'b1;
               m_we    = 1'b1;
               a_wdata = a_rdata & (m_rdata | keep_mask);
               m_wdata = '0;
            end else if (cnt_ff == CW'(WORDS)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BSAM_ASSERT_IMP(a_no_pop_in_clear, clock, reset, state_ff == ST_CLEAR, !back_ctl.pop)
   `BSAM_ASSERT_IMP(a_pop_only_idle, clock, reset, back_ctl.pop, state_ff == ST_IDLE && q_head.valid)
   `BSAM_ASSERT_IMP(a_alloc_leaves_marks, clock, reset, state_ff == ST_ALLOC, !m_we)
   `BSAM_ASSERT_NEXT(a_done_loads_rsp, clock, reset, state_ff == ST_DONE && out_free, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

### dv/tb_bitmap_slot_allocator_mark_sweep_top.sv
// Self-checking testbench for the bitmap slot allocator with mark and sweep.
module tb_bitmap_slot_allocator_mark_sweep_top;
   import bsam_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SLOTS  = 1024;
   localparam int WORDS       = POOL_SLOTS / WORD_BITS;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 2 * (WORDS + 4);

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SLOT_W-1:0] csr_data  = '0;

   // shadow of the block state
   logic [WORD_BITS-1:0] alloc_bits [WORDS];
   logic [WORD_BITS-1:0] mark_bits  [WORDS];
   logic [SLOT_W-1:0]    reserved_count;

   rsp_type queued_grants [$];
   int      fail_count     = 0;
   int      send_idle_pct  = 21;
   int      recv_idle_pct  = 55;

   bitmap_slot_allocator_mark_sweep_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // Apply one operation to the shadow maps and return the word it should produce.
   function automatic rsp_type apply_operation(req_type r);
      rsp_type res;
      logic    found;
      res   = '0;
      found = 1'b0;
      case (r.op)
         OP_ALLOC: begin
            for (int w = 0; w < WORDS && !found; w++) begin
               for (int b = 0; b < WORD_BITS && !found; b++) begin
                  if (!alloc_bits[w][b]) begin
                     alloc_bits[w][b] = 1'b1;
                     res.granted_slot = SLOT_W'(w * WORD_BITS + b);
                     found = 1'b1;
                  end
               end
            end
            res.pool_full = !found;
         end
         OP_FREE: begin
            if (int'(r.slot_index) < POOL_SLOTS)
               alloc_bits[r.slot_index[SLOT_W-1:BIT_W]][r.slot_index[BIT_W-1:0]] = 1'b0;
         end
         OP_MARK: begin
            if (int'(r.slot_index) < POOL_SLOTS)
               mark_bits[r.slot_index[SLOT_W-1:BIT_W]][r.slot_index[BIT_W-1:0]] = 1'b1;
         end
         default: begin
            for (int s = int'(reserved_count); s < POOL_SLOTS; s++) begin
               if (!mark_bits[s / WORD_BITS][s % WORD_BITS])
                  alloc_bits[s / WORD_BITS][s % WORD_BITS] = 1'b0;
            end
            for (int w = 0; w < WORDS; w++) mark_bits[w] = '0;
         end
      endcase
      return res;
   endfunction

   // Check results against the oldest prediction, then predict newly accepted words.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (queued_grants.size() == 0) begin
               $display("%0t unexpected result: expected none actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = queued_grants.pop_front();
               if (rsp_data.granted_slot !== want.granted_slot) begin
                  $display("%0t granted_slot mismatch: expected %0d actual %0d",
                           $time, want.granted_slot, rsp_data.granted_slot);
                  fail_count++;
               end
               if (rsp_data.pool_full !== want.pool_full) begin
                  $display("%0t pool_full mismatch: expected %0b actual %0b",
                           $time, want.pool_full, rsp_data.pool_full);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) queued_grants.push_back(apply_operation(req_data));
         if (csr_valid && csr_ready) reserved_count = csr_data;
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("bitmap_slot_allocator_mark_sweep_top regression: fail");
      $finish;
   end

   task automatic send_op(op_type op, logic [SLOT_W-1:0] slot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_data.op         = op;
      req_data.slot_index = slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding word has come back.
   task automatic wait_drained;
      @(negedge clock);
      req_valid = 1'b0;
      while (queued_grants.size() != 0) @(negedge clock);
   endtask

   task automatic write_reserved(logic [SLOT_W-1:0] count);
      wait_drained();
      csr_valid = 1'b1;
      csr_data  = count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Bias toward slots that are in use, so frees and marks do real work.
   function automatic logic [SLOT_W-1:0] pick_slot();
      int top;
      top = WORD_BITS - 1;
      if ($urandom_range(1) == 0) return SLOT_W'($urandom);
      for (int w = 0; w < WORDS; w++)
         if (alloc_bits[w] != '0) top = w * WORD_BITS + WORD_BITS - 1;
      return SLOT_W'($urandom_range(top));
   endfunction

   task automatic test_first_allocs;
      send_op(OP_ALLOC, '0);
      send_op(OP_ALLOC, '1);
      send_op(OP_ALLOC, 10'h2AA);
   endtask

   task automatic test_free_and_mark;
      send_op(OP_FREE, 10'd1);
      send_op(OP_ALLOC, 10'h155);
      send_op(OP_FREE, 10'd1023);         // never allocated
      send_op(OP_FREE, 10'd0);
      send_op(OP_FREE, 10'd0);            // already free
      send_op(OP_ALLOC, '0);
      send_op(OP_MARK, 10'd1023);         // marked but not allocated
      send_op(OP_MARK, 10'd0);
      send_op(OP_MARK, 10'd2);
      send_op(OP_SWEEP, '1);
      send_op(OP_ALLOC, '0);
   endtask

   task automatic test_reserved_sweep;
      write_reserved(10'd3);
      send_op(OP_ALLOC, '0);
      send_op(OP_SWEEP, '0);
      send_op(OP_ALLOC, '0);
      write_reserved(10'd1023);
      send_op(OP_SWEEP, '0);
      send_op(OP_ALLOC, '0);
   endtask

   task automatic test_pool_exhaustion;
      write_reserved(10'd0);
      send_op(OP_SWEEP, '0);
      for (int n = 0; n < POOL_SLOTS + 3; n++) send_op(OP_ALLOC, SLOT_W'($urandom));
      send_op(OP_MARK, 10'd1023);
      send_op(OP_MARK, 10'd512);
      write_reserved(10'd1023);
      send_op(OP_SWEEP, '0);
      send_op(OP_ALLOC, '0);
      send_op(OP_FREE, 10'd700);
      send_op(OP_ALLOC, '0);
      write_reserved(10'd0);
      send_op(OP_SWEEP, '0);
   endtask

   task automatic run_random_segment(int count, bit fill_mode);
      op_type            op;
      logic [SLOT_W-1:0] slot;
      int                roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (fill_mode) begin
            if (roll < 80) op = OP_ALLOC;
            else if (roll < 85) op = OP_FREE;
            else if (roll < 98) op = OP_MARK;
            else op = OP_SWEEP;
         end else begin
            if (roll < 45) op = OP_ALLOC;
            else if (roll < 65) op = OP_FREE;
            else if (roll < 94) op = OP_MARK;
            else op = OP_SWEEP;
         end
         slot = (op == OP_FREE || op == OP_MARK) ? pick_slot() : SLOT_W'($urandom);
         if ($urandom_range(99) == 0) wait_drained();
         send_op(op, slot);
      end
   endtask

   task automatic test_random;
      int                pick;
      logic [SLOT_W-1:0] count;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 21 : phase == 1 ? 55 : 0;
         recv_idle_pct = phase == 0 ? 55 : phase == 1 ? 21 : 0;
         for (int seg = 0; seg < 4; seg++) begin
            pick  = $urandom_range(3);
            count = pick == 0 ? '0 : pick == 1 ? '1 : SLOT_W'($urandom);
            write_reserved(count);
            run_random_segment(45, $urandom_range(1));
         end
      end
   endtask

   initial begin
      for (int w = 0; w < WORDS; w++) begin
         alloc_bits[w] = '0;
         mark_bits[w]  = '0;
      end
      reserved_count = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_allocs();
      test_free_and_mark();
      test_reserved_sweep();
      test_pool_exhaustion();
      test_random();

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (queued_grants.size() != 0) begin
         $display("%0t %0d results never arrived", $time, queued_grants.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("bitmap_slot_allocator_mark_sweep_top regression: pass");
      else
         $display("bitmap_slot_allocator_mark_sweep_top regression: fail");
      $finish;
   end

endmodule
